FILE: rtl/core/i2a_pkg.sv
// shared constants, types and character helpers of the integer to ascii formatter
`default_nettype none

package i2a_pkg;

    localparam int DATA_W         = 32;
    localparam int KIND_W         = 3;
    localparam int WIDTH_W        = 6;
    localparam int ROOM_W         = 8;
    localparam int CHAR_W         = 7;
    localparam int IN_TDATA_W     = 48;
    localparam int OUT_TDATA_W    = 8;
    localparam int POS_W          = 5;
    localparam int DEC_DIGITS     = 10;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [WIDTH_W-1:0] MAX_OUT   = 6'd32;
    localparam logic [WIDTH_W-1:0] WIDTH_CAP = 6'd32;

    localparam logic [KIND_W-1:0] KIND_BOOL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SDEC = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UDEC = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEX  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BIN  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic dd_step;
        logic advance;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic void_req;
        logic is_dec;
        logic dd_last;
        logic skip;
        logic last_char;
    } status_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CH_UPPER_A + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

    // index counts down to zero on the final letter
    function automatic logic [CHAR_W-1:0] bool_char(input logic is_true,
                                                    input logic [2:0] idx);
        logic [CHAR_W-1:0] c;
        if (is_true)
        begin
            case (idx)
                3'd3:    c = 7'h74;
                3'd2:    c = 7'h72;
                3'd1:    c = 7'h75;
                default: c = 7'h65;
            endcase
        end
        else
        begin
            case (idx)
                3'd4:    c = 7'h66;
                3'd3:    c = 7'h61;
                3'd2:    c = 7'h6C;
                3'd1:    c = 7'h73;
                default: c = 7'h65;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/i2a_datapath.sv
// datapath: request registers, double-dabble converter and character selection
`default_nettype none

module i2a_datapath #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [i2a_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic [i2a_pkg::KIND_W-1:0]         s_tuser,
    input  wire i2a_pkg::cmd_t                      cmd,
    output i2a_pkg::status_t                        status,
    output logic [i2a_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                    m_tlast
);

    localparam int DW        = i2a_pkg::DATA_W;
    localparam int EFF_BITS  = (VALUE_BITS < DW) ? VALUE_BITS : DW;
    localparam bit SIGN_USED = (VALUE_BITS <= DW);
    localparam int VAL_SHIFT = DW - EFF_BITS;
    localparam int DD_CW     = $clog2(EFF_BITS);
    localparam int ND        = i2a_pkg::DEC_DIGITS;
    localparam int PW        = i2a_pkg::POS_W;
    localparam int WW        = i2a_pkg::WIDTH_W;
    localparam int CW        = i2a_pkg::CHAR_W;
    localparam logic [DW-1:0] VAL_MASK = {DW{1'b1}} >> VAL_SHIFT;

    // request fields
    logic [DW-1:0]                  in_value;
    logic [WW-1:0]                  in_width;
    logic [i2a_pkg::ROOM_W-1:0]     in_room;

    assign in_value = s_tdata[DW-1:0];
    assign in_width = s_tdata[DW+WW-1:DW];
    assign in_room  = s_tdata[DW+WW+i2a_pkg::ROOM_W-1:DW+WW];

    // working registers
    logic [i2a_pkg::KIND_W-1:0]     kind_reg;
    logic [DW-1:0]                  val_reg;
    logic [3:0]                     bcd_reg [ND];
    logic [PW-1:0]                  pos_reg;
    logic [WW-1:0]                  minlen_reg;
    logic [WW-1:0]                  left_reg;
    logic                           neg_reg;
    logic                           lead_reg;
    logic [DD_CW-1:0]               dd_cnt_reg;
    logic [CW-1:0]                  char_reg;
    logic                           last_reg;

    // load values
    logic [DW-1:0]                  v_masked;
    logic                           sign_bit;
    logic                           neg_load;
    logic [DW-1:0]                  mag;
    logic [WW-1:0]                  w_clamp;
    logic [PW-1:0]                  pos_load;
    logic [WW-1:0]                  minlen_load;
    logic [WW-1:0]                  left_load;
    logic [DW-1:0]                  val_load;
    logic                           load_dec;

    always_comb
    begin
        v_masked = in_value & VAL_MASK;
        sign_bit = SIGN_USED ? v_masked[EFF_BITS-1] : 1'b0;
        neg_load = (s_tuser == i2a_pkg::KIND_SDEC) && sign_bit;
        mag      = neg_load ? ((~v_masked + DW'(1)) & VAL_MASK) : v_masked;
        load_dec = (s_tuser == i2a_pkg::KIND_SDEC) || (s_tuser == i2a_pkg::KIND_UDEC);
        val_load = load_dec ? DW'(mag << VAL_SHIFT) : v_masked;
        w_clamp  = (in_width > i2a_pkg::WIDTH_CAP) ? i2a_pkg::WIDTH_CAP : in_width;
        left_load = (in_room > 8'(i2a_pkg::MAX_OUT)) ? i2a_pkg::MAX_OUT : in_room[WW-1:0];

        pos_load    = PW'(0);
        minlen_load = 6'd32;
        case (s_tuser) inside
            i2a_pkg::KIND_BOOL:
            begin
                pos_load = (v_masked != '0) ? 5'd3 : 5'd4;
            end
            i2a_pkg::KIND_SDEC, i2a_pkg::KIND_UDEC:
            begin
                pos_load    = PW'(ND - 1);
                minlen_load = '0;
            end
            i2a_pkg::KIND_HEX:
            begin
                // nibbles above the eighth are known zero, start there only for padding
                pos_load    = (w_clamp > 6'd8) ? PW'(w_clamp - 6'd1) : 5'd7;
                minlen_load = w_clamp;
            end
            i2a_pkg::KIND_BIN:
            begin
                if (w_clamp != '0)
                begin
                    pos_load    = PW'(w_clamp - 6'd1);
                    minlen_load = 6'd32;
                end
                else
                begin
                    pos_load    = 5'd31;
                    minlen_load = '0;
                end
            end
            default:
            begin
                pos_load = '0;
            end
        endcase
    end

    // double-dabble step
    logic [3:0] adj   [ND];
    logic [3:0] bcd_sh [ND];

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        bcd_sh[0] = {adj[0][2:0], val_reg[DW-1]};
        for (int i = 1; i < ND; i++)
        begin
            bcd_sh[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    // current character
    logic [3:0]     dec_digit;
    logic [3:0]     hex_digit;
    logic           bin_bit;
    logic           digit_zero;
    logic           numeric;
    logic [CW-1:0]  cur_char;

    always_comb
    begin
        dec_digit = (pos_reg < PW'(ND)) ? bcd_reg[pos_reg[3:0]] : 4'd0;
        hex_digit = (pos_reg < 5'd8) ? val_reg[{pos_reg[2:0], 2'b00} +: 4] : 4'd0;
        bin_bit   = val_reg[pos_reg];
        numeric   = 1'b1;
        digit_zero = 1'b0;
        cur_char  = i2a_pkg::CH_ZERO;
        case (kind_reg) inside
            i2a_pkg::KIND_BOOL:
            begin
                numeric  = 1'b0;
                cur_char = i2a_pkg::bool_char(val_reg != '0, pos_reg[2:0]);
            end
            i2a_pkg::KIND_SDEC, i2a_pkg::KIND_UDEC:
            begin
                digit_zero = (dec_digit == 4'd0);
                cur_char   = neg_reg ? i2a_pkg::CH_MINUS
                                     : i2a_pkg::CH_ZERO + CW'(dec_digit);
            end
            i2a_pkg::KIND_HEX:
            begin
                digit_zero = (hex_digit == 4'd0);
                cur_char   = i2a_pkg::hex_char(hex_digit);
            end
            i2a_pkg::KIND_BIN:
            begin
                digit_zero = !bin_bit;
                cur_char   = bin_bit ? i2a_pkg::CH_ONE : i2a_pkg::CH_ZERO;
            end
            default:
            begin
                numeric = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        status.void_req  = (kind_reg > i2a_pkg::KIND_BIN) || (left_reg == '0);
        status.is_dec    = (kind_reg == i2a_pkg::KIND_SDEC) || (kind_reg == i2a_pkg::KIND_UDEC);
        status.dd_last   = (dd_cnt_reg == '0);
        // leading zero above the minimum digit count is dropped without output,
        // only until the first digit has gone out
        status.skip      = numeric && !neg_reg && lead_reg && (pos_reg != '0)
                           && ({1'b0, pos_reg} >= minlen_reg) && digit_zero;
        status.last_char = (left_reg == 6'd1) || (!neg_reg && pos_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= s_tuser;
            val_reg    <= val_load;
            pos_reg    <= pos_load;
            minlen_reg <= minlen_load;
            left_reg   <= left_load;
            neg_reg    <= neg_load;
            lead_reg   <= 1'b1;
            dd_cnt_reg <= DD_CW'(EFF_BITS - 1);
            for (int i = 0; i < ND; i++)
            begin
                bcd_reg[i] <= 4'd0;
            end
        end
        if (cmd.dd_step)
        begin
            val_reg    <= {val_reg[DW-2:0], 1'b0};
            dd_cnt_reg <= dd_cnt_reg - DD_CW'(1);
            for (int i = 0; i < ND; i++)
            begin
                bcd_reg[i] <= bcd_sh[i];
            end
        end
        if (cmd.advance)
        begin
            pos_reg <= pos_reg - PW'(1);
        end
        if (cmd.emit)
        begin
            char_reg <= cur_char;
            last_reg <= status.last_char;
            left_reg <= left_reg - WW'(1);
            if (neg_reg)
            begin
                neg_reg <= 1'b0;
            end
            else
            begin
                pos_reg  <= pos_reg - PW'(1);
                lead_reg <= 1'b0;
            end
        end
    end

    assign m_tdata = {1'b0, char_reg};
    assign m_tlast = last_reg;

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> left_reg != '0)
        else $error("character emitted beyond the room");

    a_dd_only_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dd_step |-> status.is_dec)
        else $error("conversion step on a non-decimal request");

    a_dec_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.is_dec && !neg_reg) |-> pos_reg < PW'(ND))
        else $error("decimal digit index out of range");

endmodule

`default_nettype wire

FILE: rtl/core/i2a_ctrl.sv
// controller: request handshake, sequencing of conversion and output register valid
`default_nettype none

module i2a_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire i2a_pkg::status_t   status,
    output i2a_pkg::cmd_t           cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        slot_free      = !out_valid_reg || m_tready;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.void_req)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.is_dec)
                begin
                    state_next = ST_CONVERT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_CONVERT:
            begin
                cmd.dd_step = 1'b1;
                if (status.dd_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.skip)
                begin
                    cmd.advance = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.last_char)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.dd_step, cmd.advance, cmd.emit}))
        else $error("more than one datapath command");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while held");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.last_char) |=> s_tready)
        else $error("final character not followed by idle");

endmodule

`default_nettype wire

FILE: rtl/core/integer_to_ascii_formatter_top.sv
// top level of the integer to ascii formatter: controller and datapath
`default_nettype none

// usage
// - request channel s_*: tuser carries the kind (bool, signed decimal, unsigned
//   decimal, hex, binary); tdata carries value, width and room
// - character channel m_*: one ascii character per transfer, most significant
//   first, tlast on the final character of the request
// - a request with zero room or an unknown kind produces no characters
// - at most 32 characters per request, fewer if room is smaller
// - a request is accepted, then decoded, then for decimal the value bits enter
//   the double-dabble converter one at a time (32 at the default width)
// - leading zeros are dropped without output (up to 9 for decimal, 7 for hex,
//   31 for minimal binary), then one character per cycle while the receiver
//   takes them
// - one request is worked on at a time; the next is taken in the cycle after
//   the final character has entered the output register
// - a stalled receiver holds the output register and the sequence pauses
// - reset clears the controller and the output valid; no clearing pass
// - the ready of the request channel is high only while idle

module integer_to_ascii_formatter_top #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // value[31:0], width[37:32], room[45:38], zero fill[47:46]
    input  wire logic [i2a_pkg::IN_TDATA_W-1:0] s_tdata,
    // req_type[2:0]
    input  wire logic [i2a_pkg::KIND_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // ascii_char[6:0], zero fill[7]
    output logic [i2a_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);

    // command and status between the two halves
    i2a_pkg::cmd_t      cmd;
    i2a_pkg::status_t   status;

    // sequencing and handshakes
    i2a_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // conversion and character output register
    i2a_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

`default_nettype wire
